>>> rtl/core/lph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Types, codes and constants shared by the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int CAP_W           = 9;
  localparam int LEN_W           = 4;
  localparam int KEY_BYTES       = 8;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam logic [63:0] HASH_SEED = 64'h1337_1337_dead_beef;

  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_DEL    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      found_value;
    logic [CAP_W-1:0] live_entries;
  } out_t;

  typedef struct packed {
    logic [1:0]  mark;
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [63:0]      key;
    logic [LEN_W-1:0] len;
    logic [CAP_W-1:0] cap;
  } iu_req_t;

  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] slot;
  } iu_resp_t;

endpackage
`default_nettype wire

>>> rtl/core/lph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/lph_index_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_index_unit
// Start slot: byte-serial 64-bit hash, then a bit-serial restoring modulo.
// ----------------------------------------------------------------------------
module lph_index_unit
  import lph_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire iu_req_t  req,
  output      iu_resp_t resp
);

  typedef enum logic [2:0] {
    IU_IDLE = 3'b001,
    IU_HASH = 3'b010,
    IU_MOD  = 3'b100
  } iu_state_t;

  iu_state_t        st_r;
  logic [63:0]      h_r;
  logic [63:0]      kb_r;
  logic [LEN_W-1:0] left_r;
  logic [5:0]       bit_r;
  logic [CAP_W-1:0] rem_r;
  logic [CAP_W-1:0] cap_r;

  logic [63:0]      bx;
  logic [63:0]      h_nxt;
  logic [CAP_W:0]   rem_sh;
  logic [CAP_W:0]   rem_nxt;

  assign bx      = {{56{kb_r[7]}}, kb_r[7:0]};
  assign h_nxt   = ((h_r ^ bx) << 8) + bx;
  assign rem_sh  = {rem_r, h_r[63]};
  assign rem_nxt = (rem_sh >= {1'b0, cap_r}) ? rem_sh - {1'b0, cap_r} : rem_sh;

  assign resp.done = (st_r == IU_MOD) && (bit_r == 6'd63);
  assign resp.slot = rem_nxt[CAP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IU_IDLE;
    end else begin
      unique case (st_r)
        IU_IDLE: begin
          if (req.start) begin
            h_r    <= HASH_SEED;
            kb_r   <= req.key;
            left_r <= req.len;
            cap_r  <= req.cap;
            st_r   <= IU_HASH;
          end
        end
        IU_HASH: begin
          if (left_r == '0) begin
            rem_r <= '0;
            bit_r <= '0;
            st_r  <= IU_MOD;
          end else begin
            h_r    <= h_nxt;
            kb_r   <= kb_r >> 8;
            left_r <= left_r - 1'b1;
          end
        end
        IU_MOD: begin
          rem_r <= rem_nxt[CAP_W-1:0];
          h_r   <= h_r << 1;
          bit_r <= bit_r + 1'b1;
          if (bit_r == 6'd63) begin
            st_r <= IU_IDLE;
          end
        end
        default: st_r <= IU_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/linear_probe_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps every slot of the memory to empty with busy
// high. A word is taken when start is high and busy is low; busy then stays
// high through the result word, which is shown for one cycle with out_strobe and
// cannot be held off. Each word passes an accept step, then the shared
// hash/modulo unit (byte-serial hash, one remainder bit a cycle), then a read
// step and an evaluate step per probed slot through the single-port slot
// memory, then a result step. An unused mode goes from the accept step
// straight to the result step. Write the capacity register only while busy is
// low.
module linear_probe_hash_table
  import lph_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire in_t              in_data,
  output      logic             out_strobe,
  output      out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_INDEX = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IW-1:0]    clr_r;
  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] count_r;
  logic [1:0]       mode_r;
  logic [63:0]      key_r;
  logic [63:0]      val_r;
  logic [IW-1:0]    idx_r;
  logic [CAP_W-1:0] probe_r;
  logic             tomb_seen_r;
  logic [IW-1:0]    tomb_r;
  logic [1:0]       status_r;
  logic [63:0]      found_r;

  logic [CAP_W-1:0] cap_eff;
  logic [63:0]      clean_key;
  logic [LEN_W-1:0] clean_len;
  logic             accept;
  iu_req_t          iu_req;
  iu_resp_t         iu_resp;

  logic             ram_we;
  logic [IW-1:0]    ram_addr;
  entry_t           ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd;

  logic             hit;
  logic             last;
  logic [PW-1:0]    idx_inc;
  logic [IW-1:0]    idx_next;
  logic             ev_we;
  logic [IW-1:0]    ev_addr;
  entry_t           ev_entry;
  logic             ev_finish;
  logic [1:0]       ev_status;
  logic [63:0]      ev_found;
  logic             ev_inc;
  logic             ev_dec;
  logic             ev_tomb;

  // zero capacity acts as one, oversize acts as the full depth
  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_r) > TABLE_DEPTH) begin
      cap_eff = CAP_W'(TABLE_DEPTH);
    end
  end

  // key ends at its first zero byte
  always_comb begin
    logic alive;
    alive     = 1'b1;
    clean_key = '0;
    clean_len = '0;
    for (int i = 0; i < 8; i++) begin
      if (alive && (i < KEY_BYTES) && (in_data.key[8*i +: 8] != 8'h00)) begin
        clean_key[8*i +: 8] = in_data.key[8*i +: 8];
        clean_len           = clean_len + 1'b1;
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign accept       = start && (state_r == S_IDLE);
  assign iu_req.start = accept && (in_data.mode != MODE_UNUSED);
  assign iu_req.key   = clean_key;
  assign iu_req.len   = clean_len;
  assign iu_req.cap   = cap_eff;

  lph_index_unit u_index (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (iu_req),
    .resp (iu_resp)
  );

  assign rd   = entry_t'(ram_rdata);
  assign hit  = (rd.mark == MARK_LIVE) && (rd.key == key_r);
  assign last = ({1'b0, probe_r} + 1'b1) == {1'b0, cap_eff};

  always_comb begin
    idx_inc  = PW'(idx_r) + 1'b1;
    idx_next = (idx_inc >= PW'(cap_eff)) ? '0 : IW'(idx_inc);
  end

  // decision for one probed slot
  always_comb begin
    ev_we     = 1'b0;
    ev_addr   = idx_r;
    ev_entry  = '{mark: MARK_LIVE, key: key_r, value: val_r};
    ev_finish = 1'b0;
    ev_status = STATUS_NOTFOUND;
    ev_found  = '0;
    ev_inc    = 1'b0;
    ev_dec    = 1'b0;
    ev_tomb   = 1'b0;
    priority if (hit) begin
      ev_finish = 1'b1;
      ev_status = STATUS_OK;
      unique case (mode_r)
        MODE_PUT: ev_we = 1'b1;
        MODE_GET: ev_found = rd.value;
        MODE_DEL: begin
          ev_we    = 1'b1;
          ev_entry = '{mark: MARK_TOMB, key: key_r, value: 64'd0};
          ev_dec   = (count_r != '0);
        end
        default: ev_status = STATUS_NOTFOUND;
      endcase
    end else if (rd.mark == MARK_EMPTY) begin
      ev_finish = 1'b1;
      if (mode_r == MODE_PUT) begin
        ev_we     = 1'b1;
        ev_inc    = 1'b1;
        ev_status = STATUS_OK;
      end
    end else if (last) begin
      ev_finish = 1'b1;
      if (mode_r == MODE_PUT) begin
        if (tomb_seen_r || (rd.mark == MARK_TOMB)) begin
          ev_we     = 1'b1;
          ev_addr   = tomb_seen_r ? tomb_r : idx_r;
          ev_inc    = 1'b1;
          ev_status = STATUS_OK;
        end else begin
          ev_status = STATUS_FULL;
        end
      end
    end else begin
      ev_tomb = (mode_r == MODE_PUT) && (rd.mark == MARK_TOMB) && !tomb_seen_r;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_r;
    ram_wdata = ev_entry;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '{mark: MARK_EMPTY, key: 64'd0, value: 64'd0};
      end
      S_EVAL: begin
        ram_we   = ev_we;
        ram_addr = ev_addr;
      end
      default: ram_addr = idx_r;
    endcase
  end

  lph_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == IW'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.mode == MODE_UNUSED) ? S_DONE : S_INDEX;
        end
      end
      S_INDEX: if (iu_resp.done) state_nxt = S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = ev_finish ? S_DONE : S_READ;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cap_r   <= CAP_RESET;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_EVAL) begin
        if (ev_inc) begin
          count_r <= count_r + 1'b1;
        end else if (ev_dec) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_r   <= in_data.mode;
          key_r    <= clean_key;
          val_r    <= in_data.value;
          status_r <= STATUS_NOTFOUND;
          found_r  <= '0;
        end
      end
      S_INDEX: begin
        if (iu_resp.done) begin
          idx_r       <= IW'(iu_resp.slot);
          probe_r     <= '0;
          tomb_seen_r <= 1'b0;
        end
      end
      S_EVAL: begin
        idx_r    <= idx_next;
        probe_r  <= probe_r + 1'b1;
        status_r <= ev_status;
        found_r  <= ev_found;
        if (ev_tomb) begin
          tomb_seen_r <= 1'b1;
          tomb_r      <= idx_r;
        end
      end
      default: ;
    endcase
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_strobe            = (state_r == S_DONE);
  assign out_data.status       = status_r;
  assign out_data.found_value  = found_r;
  assign out_data.live_entries = count_r;

endmodule
`default_nettype wire

>>> rtl/core/lph_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks on the hash table's command/result timing and result word.
// ----------------------------------------------------------------------------
module lph_checker
  import lph_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire out_t out_data
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result word shown while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.status == STATUS_OK || out_data.status == STATUS_NOTFOUND ||
                    out_data.status == STATUS_FULL))
    else $error("undefined status code");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != STATUS_OK) |-> (out_data.found_value == 64'd0))
    else $error("value returned on a failed request");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);
`default_nettype wire
